// ===== hdl/asnc_pkg.sv =====
package asnc_pkg;

  // Field widths
  localparam int SampleW = 12;
  localparam int ValW    = 16;
  localparam int AlphaW  = 17;
  localparam int ThrW    = 15;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 17;

  // Q16 unity for the smoothing factor
  localparam logic [AlphaW-1:0] ALPHA_ONE = AlphaW'(65536);

  // Length of a calibration window after reset
  localparam logic [ValW-1:0] CAL_LEN_RESET = ValW'(2000);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILTER_ALPHA  = 2'd0,
    CFG_INVERT_OUTPUT = 2'd1,
    CFG_CAL_LENGTH    = 2'd2
  } cfg_idx_t;

  // Calibration window state
  typedef struct packed {
    logic                active;
    logic [ValW-1:0]     count;
    logic [ValW-1:0]     ceiling;
    logic [ValW-1:0]     floor_v;
    logic [ThrW-1:0]     threshold;
    logic [ValW-1:0]     idle;
  } cal_state_t;

  // Min/max tracking state
  typedef struct packed {
    logic [ValW-1:0] max_v;
    logic [ValW-1:0] min_v;
  } ext_state_t;

endpackage

// ===== hdl/asnc_smooth.sv =====
module asnc_smooth import asnc_pkg::*; (
  input  logic [ValW-1:0]    prev,
  input  logic [SampleW-1:0] sample,
  input  logic [AlphaW-1:0]  alpha,
  output logic [ValW-1:0]    value
);

  logic [ValW-1:0]       wide_x;
  logic signed [ValW:0]  diff;
  logic signed [AlphaW:0] alpha_s;
  logic signed [34:0]    prod;
  logic                  filter_on;

  // Widen the sample to 16 bits
  assign wide_x = {sample, 4'b0000};

  // Filter off at zero and above unity
  assign filter_on = (alpha != '0) && (alpha <= ALPHA_ONE);

  // prev + floor(alpha * (x - prev) / 65536); arithmetic shift floors,
  // only the low 16 bits of the quotient reach the wrapped sum
  assign diff    = $signed({1'b0, wide_x}) - $signed({1'b0, prev});
  assign alpha_s = $signed({1'b0, alpha});
  assign prod    = 35'(alpha_s * diff);

  assign value = filter_on ? ValW'(prev + prod[31:16]) : wide_x;

endmodule

// ===== hdl/asnc_calib.sv =====
module asnc_calib import asnc_pkg::*; (
  input  cal_state_t      cur,
  input  logic [ValW-1:0] value,
  input  logic            start,
  input  logic [ValW-1:0] cal_len,
  output cal_state_t      nxt,
  output logic            done
);

  logic            active;
  logic [ValW-1:0] span;
  logic [ThrW-1:0] thr;

  assign active = cur.active | start;
  assign span   = cur.ceiling - cur.floor_v;
  assign thr    = span[ValW-1:1];

  // Gather ceiling/floor while the count is below the length, close after
  always_comb begin
    nxt  = cur;
    done = 1'b0;
    nxt.active = active;
    if (active) begin
      if (cur.count < cal_len) begin
        if (cur.count == '0) begin
          nxt.ceiling = value;
          nxt.floor_v = value;
        end else if (value > cur.ceiling) begin
          nxt.ceiling = value;
        end else if (value < cur.floor_v) begin
          nxt.floor_v = value;
        end
        nxt.count = cur.count + ValW'(1);
      end else begin
        nxt.active    = 1'b0;
        nxt.count     = '0;
        nxt.threshold = thr;
        nxt.idle      = cur.floor_v + ValW'(thr);
        done          = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/asnc_extreme.sv =====
module asnc_extreme import asnc_pkg::*; (
  input  ext_state_t      cur,
  input  logic [ValW-1:0] rd,
  input  logic            reseed,
  output ext_state_t      nxt
);

  ext_state_t seeded;

  // Optional reseed around the reading, saturated at both ends
  always_comb begin
    seeded = cur;
    if (reseed) begin
      seeded.max_v = (rd == '1) ? rd : rd + ValW'(1);
      seeded.min_v = (rd == '0) ? rd : rd - ValW'(1);
    end
  end

  // Independent max and min compares
  always_comb begin
    nxt.max_v = (rd > seeded.max_v) ? rd : seeded.max_v;
    nxt.min_v = (rd < seeded.min_v) ? rd : seeded.min_v;
  end

endmodule

// ===== hdl/adc_smoothing_noise_calibrator_core.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   adc_sample, start_calibration, reseed_extremes
// out_      output     out_valid/out_stall reading, calibrating, calibration_done,
//                                          noise_threshold, idle_level, tracked_max/min
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes through
// the input register, then the smoother multiply-add and compares into the result register,
// which raises out_valid. Reset (rst_n low, synchronous) clears the valid flags and item
// state and loads the register defaults; the payload registers are not reset.
// out_stall holds the result register; the input register still takes an item
// while the result waits, and in_stall rises only when both are full.
// cfg_ready is always high.
module adc_smoothing_noise_calibrator_core import asnc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [SampleW-1:0] in_adc_sample,
  input  logic               in_start_calibration,
  input  logic               in_reseed_extremes,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [ValW-1:0]    out_reading,
  output logic               out_calibrating,
  output logic               out_calibration_done,
  output logic [ThrW-1:0]    out_noise_threshold,
  output logic [ValW-1:0]    out_idle_level,
  output logic [ValW-1:0]    out_tracked_max,
  output logic [ValW-1:0]    out_tracked_min,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgDatW-1:0] cfg_data
);

  // Configuration registers
  logic [AlphaW-1:0] alpha_r;
  logic              invert_r;
  logic [ValW-1:0]   cal_len_r;

  // Input register
  logic               s1_valid_r;
  logic [SampleW-1:0] s1_sample_r;
  logic               s1_start_r;
  logic               s1_reseed_r;

  // Item state
  logic [ValW-1:0] cur_val_r;
  cal_state_t      cal_r;
  ext_state_t      ext_r;

  // Result register
  logic            out_valid_r;
  logic [ValW-1:0] out_reading_r;
  logic            out_cal_r;
  logic            out_done_r;
  logic [ThrW-1:0] out_thr_r;
  logic [ValW-1:0] out_idle_r;
  logic [ValW-1:0] out_max_r;
  logic [ValW-1:0] out_min_r;

  logic            s2_load;
  logic            s1_load;
  logic [ValW-1:0] cur_val_nxt;
  logic [ValW-1:0] rd_nxt;
  cal_state_t      cal_nxt;
  ext_state_t      ext_nxt;
  logic            done_nxt;

  // Handshake
  assign s2_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Datapath
  asnc_smooth u_smooth (
    .prev   (cur_val_r),
    .sample (s1_sample_r),
    .alpha  (alpha_r),
    .value  (cur_val_nxt)
  );

  asnc_calib u_calib (
    .cur     (cal_r),
    .value   (cur_val_nxt),
    .start   (s1_start_r),
    .cal_len (cal_len_r),
    .nxt     (cal_nxt),
    .done    (done_nxt)
  );

  assign rd_nxt = invert_r ? ~cur_val_nxt : cur_val_nxt;

  asnc_extreme u_extreme (
    .cur    (ext_r),
    .rd     (rd_nxt),
    .reseed (s1_reseed_r),
    .nxt    (ext_nxt)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r   <= '0;
      invert_r  <= 1'b0;
      cal_len_r <= CAL_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FILTER_ALPHA:  alpha_r   <= cfg_data;
        CFG_INVERT_OUTPUT: invert_r  <= cfg_data[0];
        CFG_CAL_LENGTH:    cal_len_r <= cfg_data[ValW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s2_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_sample_r <= in_adc_sample;
      s1_start_r  <= in_start_calibration;
      s1_reseed_r <= in_reseed_extremes;
    end
  end

  // State update, one item per load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_val_r <= '0;
      cal_r     <= '0;
      ext_r.max_v <= '0;
      ext_r.min_v <= '1;
    end else if (s2_load) begin
      cur_val_r <= cur_val_nxt;
      cal_r     <= cal_nxt;
      ext_r     <= ext_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_reading_r <= rd_nxt;
      out_cal_r     <= cal_nxt.active;
      out_done_r    <= done_nxt;
      out_thr_r     <= cal_nxt.threshold;
      out_idle_r    <= cal_nxt.idle;
      out_max_r     <= ext_nxt.max_v;
      out_min_r     <= ext_nxt.min_v;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_reading          = out_reading_r;
  assign out_calibrating      = out_cal_r;
  assign out_calibration_done = out_done_r;
  assign out_noise_threshold  = out_thr_r;
  assign out_idle_level       = out_idle_r;
  assign out_tracked_max      = out_max_r;
  assign out_tracked_min      = out_min_r;

  // Checks
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_cal_r)
    else $error("calibration_done with window still open");

  a_extremes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_max_r >= out_reading_r) && (out_min_r <= out_reading_r))
    else $error("tracked extremes do not bound the reading");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!s2_load) |=> $stable(cur_val_r) && $stable(cal_r))
    else $error("item state changed without an item");

endmodule
